@@ hw/rtl/smeg_pkg.sv @@
// ----------------------------------------------------------------------------
// smeg_pkg
// shared types, codes and helper functions of the stencil mesh edge generator
// ----------------------------------------------------------------------------
package smeg_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int MAX_EXTENT_DEF   = 64;

    // fixed internal widths, wide enough for the whole parameter range
    localparam int IDX_W       = 16;
    localparam int CNT_W       = 17;
    localparam int DEG_W       = 4;
    localparam int WGT_W       = 16;
    localparam int SIZE_W      = 7;
    localparam int CRD_W       = 6;
    localparam int QRY_W       = 12;
    localparam int OUT_IDX_W   = 12;
    localparam int VAL_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEG_W-1:0] DEG_MAX = 4'd15;

    typedef enum logic [1:0] {
        OP_VISIT  = 2'd0,
        OP_DEGREE = 2'd1,
        OP_LCM    = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_DEGREE = 2'd1,
        KIND_LCM    = 2'd2,
        KIND_NOEDGE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_EDGES,
        CMD_NOEDGE,
        CMD_DEGREE,
        CMD_LCM
    } t_cmd_kind;

    typedef enum logic [2:0] {
        REG_SIZE_X   = 3'd0,
        REG_SIZE_Y   = 3'd1,
        REG_SIZE_Z   = 3'd2,
        REG_STENCIL  = 3'd3,
        REG_PERIODIC = 3'd4,
        REG_WEIGHT_X = 3'd5,
        REG_WEIGHT_Y = 3'd6,
        REG_WEIGHT_Z = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        F_IDLE,
        F_GEOM,
        F_SPAN,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_EDGE,
        B_WR_S,
        B_WR_R,
        B_DEG_RD,
        B_DEG_CAP,
        B_LCM_RUN,
        B_LCM_TAIL,
        B_LCM_MUL,
        B_REPLY
    } t_back_state;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [5:0]        stencil_mask;
        logic [2:0]        periodic_mask;
        logic [WGT_W-1:0]  weight_x;
        logic [WGT_W-1:0]  weight_y;
        logic [WGT_W-1:0]  weight_z;
    } t_cfg;

    // classified item handed from the front to the back
    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] recv;
        logic [5:0]       emit;
        logic [5:0]       wrap;
        logic [IDX_W-1:0] stride1;
        logic [IDX_W-1:0] stride2;
        logic [IDX_W-1:0] wd0;
        logic [IDX_W-1:0] wd1;
        logic [IDX_W-1:0] wd2;
        logic [IDX_W-1:0] query;
        logic             q_ok;
        logic [CNT_W-1:0] lim;
    } t_cmd;

    typedef struct packed {
        t_kind                kind;
        logic [OUT_IDX_W-1:0] sender;
        logic [OUT_IDX_W-1:0] receiver;
        logic [1:0]           axis;
        logic [WGT_W-1:0]     edge_weight;
        logic [VAL_W-1:0]     value;
        logic                 last;
    } t_result;

    // lcm of degrees 1..15 kept as prime exponents
    typedef struct packed {
        logic       zero;
        logic [1:0] e2;
        logic [1:0] e3;
        logic       p5;
        logic       p7;
        logic       p11;
        logic       p13;
    } t_lcm_acc;

    localparam t_lcm_acc LCM_ONE = '0;

    function automatic logic [DEG_W-1:0] deg_step(logic [DEG_W-1:0] d, logic two);
        logic [DEG_W:0] s;
        s = {1'b0, d} + (two ? 5'd2 : 5'd1);
        return (s > {1'b0, DEG_MAX}) ? DEG_MAX : s[DEG_W-1:0];
    endfunction

    function automatic t_lcm_acc lcm_merge(t_lcm_acc a, logic [DEG_W-1:0] d);
        t_lcm_acc   r;
        logic [1:0] n2;
        logic [1:0] n3;
        logic       z;
        logic       f5;
        logic       f7;
        logic       f11;
        logic       f13;
        r   = a;
        n2  = 2'd0;
        n3  = 2'd0;
        z   = 1'b0;
        f5  = 1'b0;
        f7  = 1'b0;
        f11 = 1'b0;
        f13 = 1'b0;
        unique case (d)
            4'd0:  z = 1'b1;
            4'd1:  ;
            4'd2:  n2 = 2'd1;
            4'd3:  n3 = 2'd1;
            4'd4:  n2 = 2'd2;
            4'd5:  f5 = 1'b1;
            4'd6:  begin n2 = 2'd1; n3 = 2'd1; end
            4'd7:  f7 = 1'b1;
            4'd8:  n2 = 2'd3;
            4'd9:  n3 = 2'd2;
            4'd10: begin n2 = 2'd1; f5 = 1'b1; end
            4'd11: f11 = 1'b1;
            4'd12: begin n2 = 2'd2; n3 = 2'd1; end
            4'd13: f13 = 1'b1;
            4'd14: begin n2 = 2'd1; f7 = 1'b1; end
            4'd15: begin n3 = 2'd1; f5 = 1'b1; end
        endcase
        r.zero = a.zero | z;
        r.e2   = (n2 > a.e2) ? n2 : a.e2;
        r.e3   = (n3 > a.e3) ? n3 : a.e3;
        r.p5   = a.p5 | f5;
        r.p7   = a.p7 | f7;
        r.p11  = a.p11 | f11;
        r.p13  = a.p13 | f13;
        return r;
    endfunction

    // 2^e2 * 3^e3
    function automatic logic [6:0] lcm_low(t_lcm_acc a);
        logic [6:0] v;
        unique case ({a.e2, a.e3})
            4'b0000: v = 7'd1;
            4'b0001: v = 7'd3;
            4'b0010: v = 7'd9;
            4'b0100: v = 7'd2;
            4'b0101: v = 7'd6;
            4'b0110: v = 7'd18;
            4'b1000: v = 7'd4;
            4'b1001: v = 7'd12;
            4'b1010: v = 7'd36;
            4'b1100: v = 7'd8;
            4'b1101: v = 7'd24;
            4'b1110: v = 7'd72;
            default: v = 7'd1;
        endcase
        return v;
    endfunction

    // product of the odd primes 5, 7, 11, 13 that are present
    function automatic logic [12:0] lcm_high(t_lcm_acc a);
        logic [12:0] v;
        unique case ({a.p13, a.p11, a.p7, a.p5})
            4'b0000: v = 13'd1;
            4'b0001: v = 13'd5;
            4'b0010: v = 13'd7;
            4'b0011: v = 13'd35;
            4'b0100: v = 13'd11;
            4'b0101: v = 13'd55;
            4'b0110: v = 13'd77;
            4'b0111: v = 13'd385;
            4'b1000: v = 13'd13;
            4'b1001: v = 13'd65;
            4'b1010: v = 13'd91;
            4'b1011: v = 13'd455;
            4'b1100: v = 13'd143;
            4'b1101: v = 13'd715;
            4'b1110: v = 13'd1001;
            4'b1111: v = 13'd5005;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/smeg_ram.sv @@
// ----------------------------------------------------------------------------
// smeg_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module smeg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/smeg_queue.sv @@
// ----------------------------------------------------------------------------
// smeg_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module smeg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smeg_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output smeg_pkg::t_cmd  o_cmd,
    output logic            o_empty
);

    localparam int D  = smeg_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int NW = $clog2(D + 1);

    smeg_pkg::t_cmd  r_slot [D];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [NW-1:0]   r_count;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic [NW-1:0]   n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(D - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(D - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rptr];
    assign o_full  = (r_count == NW'(D));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

endmodule

@@ hw/rtl/smeg_front.sv @@
// ----------------------------------------------------------------------------
// smeg_front
// accepts items, works out grid geometry and classifies each item
// ----------------------------------------------------------------------------
module smeg_front #(
    parameter int MAX_VERTICES = smeg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EXTENT   = smeg_pkg::MAX_EXTENT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smeg_pkg::t_cfg  i_cfg,
    input  logic            i_hold,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [31:0]     i_s_tdata,
    output logic            o_push,
    output smeg_pkg::t_cmd  o_cmd,
    input  logic            i_full
);

    localparam int SW      = smeg_pkg::SIZE_W;
    localparam int CW      = smeg_pkg::CRD_W;
    localparam int IW      = smeg_pkg::IDX_W;
    localparam int NW      = smeg_pkg::CNT_W;
    localparam int EXT_CAP = (MAX_EXTENT < 127) ? MAX_EXTENT : 127;
    localparam logic [SW-1:0] EXT_CAP_V = SW'(EXT_CAP);
    localparam logic [20:0]   MAXV_21   = 21'(MAX_VERTICES);
    localparam logic [16:0]   MAXV_17   = 17'(MAX_VERTICES);

    function automatic logic [SW-1:0] eff_size(logic [SW-1:0] s);
        logic [SW-1:0] r;
        if (s == '0) begin
            r = SW'(1);
        end else if (s > EXT_CAP_V) begin
            r = EXT_CAP_V;
        end else begin
            r = s;
        end
        return r;
    endfunction

    smeg_pkg::t_front_state r_state;
    smeg_pkg::t_front_state n_state;

    smeg_pkg::t_opcode                r_op;
    logic [CW-1:0]                    r_c0;
    logic [CW-1:0]                    r_c1;
    logic [CW-1:0]                    r_c2;
    logic [smeg_pkg::QRY_W-1:0]       r_q;
    logic [SW-1:0]                    r_s0;
    logic [SW-1:0]                    r_s1;
    logic [SW-1:0]                    r_s2;
    logic [13:0]                      r_s01;
    logic [SW-1:0]                    r_wd0;
    logic [20:0]                      r_total;
    logic [12:0]                      r_p1;
    logic [19:0]                      r_p2;
    logic [13:0]                      r_wd1;
    logic [20:0]                      r_wd2;

    logic          w_accept;
    logic [SW-1:0] w_s0;
    logic [SW-1:0] w_s1;
    logic [SW-1:0] w_s2;

    assign w_s0 = eff_size(i_cfg.size_x);
    assign w_s1 = eff_size(i_cfg.size_y);
    assign w_s2 = eff_size(i_cfg.size_z);

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_push     = 1'b0;
        w_accept   = 1'b0;
        unique case (r_state)
            smeg_pkg::F_IDLE: begin
                o_s_tready = !i_hold;
                w_accept   = i_s_tvalid && !i_hold;
                // unused opcode is dropped without a result
                if (w_accept && (smeg_pkg::t_opcode'(i_s_tdata[1:0]) != smeg_pkg::OP_NONE)) begin
                    n_state = smeg_pkg::F_GEOM;
                end
            end
            smeg_pkg::F_GEOM: begin
                n_state = smeg_pkg::F_SPAN;
            end
            smeg_pkg::F_SPAN: begin
                n_state = smeg_pkg::F_PUSH;
            end
            smeg_pkg::F_PUSH: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_state = smeg_pkg::F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smeg_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= smeg_pkg::t_opcode'(i_s_tdata[1:0]);
            r_c0 <= i_s_tdata[7:2];
            r_c1 <= i_s_tdata[13:8];
            r_c2 <= i_s_tdata[19:14];
            r_q  <= i_s_tdata[31:20];
        end
        if (r_state == smeg_pkg::F_GEOM) begin
            r_s0  <= w_s0;
            r_s1  <= w_s1;
            r_s2  <= w_s2;
            r_s01 <= 14'(w_s0) * 14'(w_s1);
            r_wd0 <= w_s0 - SW'(1);
        end
        if (r_state == smeg_pkg::F_SPAN) begin
            r_total <= 21'(r_s01) * 21'(r_s2);
            r_p1    <= 13'(r_c1) * 13'(r_s0);
            r_p2    <= 20'(r_c2) * 20'(r_s01);
            r_wd1   <= 14'(r_s1 - SW'(1)) * 14'(r_s0);
            r_wd2   <= 21'(r_s2 - SW'(1)) * 21'(r_s01);
        end
    end

    // classification of the held item
    logic [CW-1:0] w_c [3];
    logic [SW-1:0] w_s [3];
    logic [20:0]   w_recv;
    logic          w_over;
    logic          w_oob;
    logic [5:0]    w_emit;
    logic [5:0]    w_wrap;

    always_comb begin
        logic at_lo;
        logic at_hi;
        w_c[0] = r_c0;
        w_c[1] = r_c1;
        w_c[2] = r_c2;
        w_s[0] = r_s0;
        w_s[1] = r_s1;
        w_s[2] = r_s2;
        w_recv = 21'(r_c0) + 21'(r_p1) + 21'(r_p2);
        w_over = (r_total > MAXV_21);
        w_oob  = 1'b0;
        w_emit = '0;
        w_wrap = '0;
        for (int ax = 0; ax < 3; ax++) begin
            at_lo = (w_c[ax] == '0);
            at_hi = ((SW'(w_c[ax]) + SW'(1)) >= w_s[ax]);
            if (SW'(w_c[ax]) >= w_s[ax]) begin
                w_oob = 1'b1;
            end
            w_wrap[2*ax]     = at_lo;
            w_wrap[2*ax + 1] = at_hi;
            w_emit[2*ax]     = i_cfg.stencil_mask[2*ax]
                               && (!at_lo || i_cfg.periodic_mask[ax]);
            w_emit[2*ax + 1] = i_cfg.stencil_mask[2*ax + 1]
                               && (!at_hi || i_cfg.periodic_mask[ax]);
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.recv    = w_recv[IW-1:0];
        o_cmd.emit    = w_emit;
        o_cmd.wrap    = w_wrap;
        o_cmd.stride1 = IW'(r_s0);
        o_cmd.stride2 = IW'(r_s01);
        o_cmd.wd0     = IW'(r_wd0);
        o_cmd.wd1     = IW'(r_wd1);
        o_cmd.wd2     = r_wd2[IW-1:0];
        o_cmd.query   = IW'(r_q);
        o_cmd.q_ok    = (17'(r_q) < MAXV_17);
        o_cmd.lim     = w_over ? NW'(MAX_VERTICES) : r_total[NW-1:0];
        unique case (r_op)
            smeg_pkg::OP_VISIT: begin
                o_cmd.kind = (w_over || w_oob || (w_emit == '0)) ? smeg_pkg::CMD_NOEDGE
                                                                 : smeg_pkg::CMD_EDGES;
            end
            smeg_pkg::OP_DEGREE: o_cmd.kind = smeg_pkg::CMD_DEGREE;
            smeg_pkg::OP_LCM:    o_cmd.kind = smeg_pkg::CMD_LCM;
            default:             o_cmd.kind = smeg_pkg::CMD_NOEDGE;
        endcase
    end

endmodule

@@ hw/rtl/smeg_back.sv @@
// ----------------------------------------------------------------------------
// smeg_back
// carries out commands: emits edges, keeps the degree store, degree and lcm
// ----------------------------------------------------------------------------
module smeg_back #(
    parameter int MAX_VERTICES = smeg_pkg::MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smeg_pkg::t_cfg    i_cfg,
    input  logic              i_empty,
    output logic              o_pop,
    input  smeg_pkg::t_cmd    i_cmd,
    output logic              o_clearing,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output smeg_pkg::t_result o_res
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = smeg_pkg::CNT_W;
    localparam int IW = smeg_pkg::IDX_W;
    localparam int DW = smeg_pkg::DEG_W;
    localparam int VW = smeg_pkg::VAL_W;

    smeg_pkg::t_back_state r_state;
    smeg_pkg::t_back_state n_state;
    logic [NW-1:0]         r_cnt;
    logic [NW-1:0]         n_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;

    smeg_pkg::t_cmd        r_cmd;
    smeg_pkg::t_cmd        n_cmd;
    logic [5:0]            r_left;
    logic [5:0]            n_left;
    logic [IW-1:0]         r_snd;
    logic [IW-1:0]         n_snd;
    smeg_pkg::t_lcm_acc    r_acc;
    smeg_pkg::t_lcm_acc    n_acc;
    logic [VW-1:0]         r_val;
    logic [VW-1:0]         n_val;
    logic                  r_pv;
    logic                  n_pv;
    smeg_pkg::t_result     r_out;
    smeg_pkg::t_result     n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    smeg_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_degree_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next direction of the current visit and its sender
    logic [2:0]                 w_sel;
    logic [1:0]                 w_ax;
    logic                       w_wrapped;
    logic [IW-1:0]              w_mag;
    logic [IW-1:0]              w_snd;
    logic [smeg_pkg::WGT_W-1:0] w_wgt;
    logic [5:0]                 w_rest;
    logic                       w_out_free;
    logic [19:0]                w_prod;

    always_comb begin
        w_sel = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (r_left[i]) begin
                w_sel = 3'(i);
            end
        end
        w_ax      = w_sel[2:1];
        w_wrapped = r_cmd.wrap[w_sel];
        unique case (w_ax)
            2'd0: begin
                w_mag = w_wrapped ? r_cmd.wd0 : IW'(1);
                w_wgt = i_cfg.weight_x;
            end
            2'd1: begin
                w_mag = w_wrapped ? r_cmd.wd1 : r_cmd.stride1;
                w_wgt = i_cfg.weight_y;
            end
            2'd2: begin
                w_mag = w_wrapped ? r_cmd.wd2 : r_cmd.stride2;
                w_wgt = i_cfg.weight_z;
            end
            default: begin
                w_mag = '0;
                w_wgt = '0;
            end
        endcase
        // upward interior or downward wrap moves to a higher index
        w_snd  = (w_sel[0] != w_wrapped) ? (r_cmd.recv + w_mag) : (r_cmd.recv - w_mag);
        w_rest = r_left & ~(6'd1 << w_sel);
    end

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_prod     = 20'(smeg_pkg::lcm_low(r_acc)) * 20'(smeg_pkg::lcm_high(r_acc));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_left    = r_left;
        n_snd     = r_snd;
        n_acc     = r_acc;
        n_val     = r_val;
        n_pv      = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        o_pop     = 1'b0;
        n_out_valid = i_m_ready ? 1'b0 : r_out_valid;

        unique case (r_state)
            smeg_pkg::B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == NW'(MAX_VERTICES - 1)) begin
                    n_state = smeg_pkg::B_IDLE;
                end
            end
            smeg_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        smeg_pkg::CMD_EDGES: begin
                            n_left  = i_cmd.emit;
                            n_state = smeg_pkg::B_EDGE;
                        end
                        smeg_pkg::CMD_NOEDGE: begin
                            n_val   = '0;
                            n_state = smeg_pkg::B_REPLY;
                        end
                        smeg_pkg::CMD_DEGREE: begin
                            n_state = smeg_pkg::B_DEG_RD;
                        end
                        smeg_pkg::CMD_LCM: begin
                            n_cnt   = '0;
                            n_acc   = smeg_pkg::LCM_ONE;
                            n_state = smeg_pkg::B_LCM_RUN;
                        end
                    endcase
                end
            end
            smeg_pkg::B_EDGE: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = smeg_pkg::KIND_EDGE;
                    n_out.sender      = w_snd[smeg_pkg::OUT_IDX_W-1:0];
                    n_out.receiver    = r_cmd.recv[smeg_pkg::OUT_IDX_W-1:0];
                    n_out.axis        = w_ax;
                    n_out.edge_weight = w_wgt;
                    n_out.value       = '0;
                    n_out.last        = (w_rest == '0);
                    n_left            = w_rest;
                    n_snd             = w_snd;
                    ram_re            = 1'b1;
                    ram_raddr         = w_snd[AW-1:0];
                    n_state           = smeg_pkg::B_WR_S;
                end
            end
            smeg_pkg::B_WR_S: begin
                ram_we    = 1'b1;
                ram_waddr = r_snd[AW-1:0];
                if (r_snd == r_cmd.recv) begin
                    // self edge: both bumps land on one entry
                    ram_wdata = smeg_pkg::deg_step(ram_rdata, 1'b1);
                    n_state   = (r_left == '0) ? smeg_pkg::B_IDLE : smeg_pkg::B_EDGE;
                end else begin
                    ram_wdata = smeg_pkg::deg_step(ram_rdata, 1'b0);
                    ram_re    = 1'b1;
                    ram_raddr = r_cmd.recv[AW-1:0];
                    n_state   = smeg_pkg::B_WR_R;
                end
            end
            smeg_pkg::B_WR_R: begin
                ram_we    = 1'b1;
                ram_waddr = r_cmd.recv[AW-1:0];
                ram_wdata = smeg_pkg::deg_step(ram_rdata, 1'b0);
                n_state   = (r_left == '0) ? smeg_pkg::B_IDLE : smeg_pkg::B_EDGE;
            end
            smeg_pkg::B_DEG_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cmd.query[AW-1:0];
                n_state   = smeg_pkg::B_DEG_CAP;
            end
            smeg_pkg::B_DEG_CAP: begin
                n_val   = r_cmd.q_ok ? VW'(ram_rdata) : '0;
                n_state = smeg_pkg::B_REPLY;
            end
            smeg_pkg::B_LCM_RUN: begin
                ram_re    = 1'b1;
                ram_raddr = r_cnt[AW-1:0];
                n_cnt     = r_cnt + 1'b1;
                n_pv      = 1'b1;
                if (r_pv) begin
                    n_acc = smeg_pkg::lcm_merge(r_acc, ram_rdata);
                end
                if (r_cnt == (r_cmd.lim - NW'(1))) begin
                    n_state = smeg_pkg::B_LCM_TAIL;
                end
            end
            smeg_pkg::B_LCM_TAIL: begin
                n_acc   = smeg_pkg::lcm_merge(r_acc, ram_rdata);
                n_state = smeg_pkg::B_LCM_MUL;
            end
            smeg_pkg::B_LCM_MUL: begin
                if (r_acc.zero) begin
                    n_val = '0;
                end else if (w_prod > 20'hFFFF) begin
                    n_val = '1;
                end else begin
                    n_val = w_prod[VW-1:0];
                end
                n_state = smeg_pkg::B_REPLY;
            end
            smeg_pkg::B_REPLY: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.value       = r_val;
                    n_out.last        = 1'b1;
                    unique case (r_cmd.kind)
                        smeg_pkg::CMD_DEGREE: n_out.kind = smeg_pkg::KIND_DEGREE;
                        smeg_pkg::CMD_LCM:    n_out.kind = smeg_pkg::KIND_LCM;
                        smeg_pkg::CMD_NOEDGE: n_out.kind = smeg_pkg::KIND_NOEDGE;
                        smeg_pkg::CMD_EDGES:  n_out.kind = smeg_pkg::KIND_EDGE;
                    endcase
                    n_state = smeg_pkg::B_IDLE;
                end
            end
            default: n_state = smeg_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smeg_pkg::B_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_left <= n_left;
        r_snd  <= n_snd;
        r_acc  <= n_acc;
        r_val  <= n_val;
        r_out  <= n_out;
    end

    assign o_clearing = (r_state == smeg_pkg::B_CLEAR);
    assign o_m_valid  = r_out_valid;
    assign o_res      = r_out;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smeg_pkg::B_CLEAR) |-> !o_pop)
        else $error("command taken during the clearing pass");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != smeg_pkg::B_CLEAR) |=> (r_state != smeg_pkg::B_CLEAR))
        else $error("clearing pass restarted without reset");

    a_rmw_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("degree read and write hit one entry in the same cycle");

    a_sender_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == smeg_pkg::B_EDGE) && w_out_free) |-> (NW'(w_snd) < r_cmd.lim))
        else $error("edge sender outside the grid");

endmodule

@@ hw/rtl/stencil_mesh_edge_generator.sv @@
// ----------------------------------------------------------------------------
// stencil_mesh_edge_generator
// six-point stencil edge generator for a 3d cartesian mesh with degree store
// ----------------------------------------------------------------------------
// usage:
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; registers take effect for the next item.
//   input items on the s channel: visit, degree read or lcm report.
//   results on the m channel: one item per edge, or a single reply item;
//   o_m_tlast marks the final result of each input item.
// processing:
//   an item passes through the front (capture, two multiply stages,
//   classify) and then waits in a 2-entry queue for the back.
//   a visit in the back passes each emitted edge through the edge, sender
//   write and receiver write states (a self edge skips the receiver write)
//   for the read-modify-write of both ends in the dual-port degree ram; a
//   visit without edges goes straight to the reply, a degree read reads first.
//   an lcm report walks the store at one entry a cycle.
// reset:
//   registers return to their reset values; the degree ram is then cleared
//   one entry a cycle, all MAX_VERTICES entries (4096 by default), during
//   which o_s_tready stays low.
// stall:
//   a result waits in the output register while o_m_tvalid is high and
//   i_m_tready low; the front and the queue keep taking items meanwhile until the queue is full.
// ----------------------------------------------------------------------------
module stencil_mesh_edge_generator #(
    parameter int MAX_VERTICES = smeg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EXTENT   = smeg_pkg::MAX_EXTENT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // opcode[1:0], coord_i[7:2], coord_j[13:8], coord_k[19:14], query_vertex[31:20]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // sender[11:0], receiver[23:12], axis[25:24], edge_weight[41:26],
    // value[57:42], zero fill[63:58]
    output logic [63:0] o_m_tdata,
    // kind[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    smeg_pkg::t_cfg    r_cfg;
    smeg_pkg::t_cmd    w_push_cmd;
    smeg_pkg::t_cmd    w_pop_cmd;
    smeg_pkg::t_result w_res;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    logic              w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x        <= 7'd1;
            r_cfg.size_y        <= 7'd1;
            r_cfg.size_z        <= 7'd1;
            r_cfg.stencil_mask  <= 6'd63;
            r_cfg.periodic_mask <= 3'd0;
            r_cfg.weight_x      <= 16'd1;
            r_cfg.weight_y      <= 16'd1;
            r_cfg.weight_z      <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (smeg_pkg::t_reg_idx'(i_cfg_idx))
                smeg_pkg::REG_SIZE_X:   r_cfg.size_x        <= i_cfg_data[6:0];
                smeg_pkg::REG_SIZE_Y:   r_cfg.size_y        <= i_cfg_data[6:0];
                smeg_pkg::REG_SIZE_Z:   r_cfg.size_z        <= i_cfg_data[6:0];
                smeg_pkg::REG_STENCIL:  r_cfg.stencil_mask  <= i_cfg_data[5:0];
                smeg_pkg::REG_PERIODIC: r_cfg.periodic_mask <= i_cfg_data[2:0];
                smeg_pkg::REG_WEIGHT_X: r_cfg.weight_x      <= i_cfg_data;
                smeg_pkg::REG_WEIGHT_Y: r_cfg.weight_y      <= i_cfg_data;
                smeg_pkg::REG_WEIGHT_Z: r_cfg.weight_z      <= i_cfg_data;
            endcase
        end
    end

    smeg_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EXTENT   (MAX_EXTENT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hold     (w_clearing),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_full     (w_full)
    );

    smeg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    smeg_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_cmd      (w_pop_cmd),
        .o_clearing (w_clearing),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_res      (w_res)
    );

    assign o_m_tdata = {6'd0, w_res.value, w_res.edge_weight, w_res.axis,
                        w_res.receiver, w_res.sender};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last;

endmodule
